/* sv/m2h_pkg.sv */
// ============================================================================
// m2h_pkg - shared types and constants for the streaming MurmurHash2 block
// Holds the channel payloads, the queue entry, the back-end state encoding
// and the fixed mixing constants of the 32-bit hash.
// ============================================================================
package m2h_pkg;

   // Mixing constants of the 32-bit hash.
   localparam logic [31:0] MIX_MULT      = 32'h5bd1e995;
   localparam int unsigned MIX_SHIFT     = 24;
   localparam int unsigned FINAL_SHIFT_A = 13;
   localparam int unsigned FINAL_SHIFT_B = 15;

   // Number of bytes in a full message word.
   localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

   // Depth of the queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 2;

   // Configuration register indexes (taken from paddr bit 2).
   localparam logic CSR_IDX_SEED  = 1'b0;
   localparam logic CSR_IDX_ORDER = 1'b1;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        first_item;
      logic        last_item;
      logic [31:0] message_length;
   } m2h_req_type;

   typedef struct packed {
      logic [31:0] hash_value;
      logic        length_error;
   } m2h_rsp_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_TAIL,
      KIND_FULL
   } m2h_kind_type;

   // One classified item as it travels from front to back.
   typedef struct packed {
      m2h_kind_type kind;
      logic [31:0]  word;        // byte-ordered full word or masked tail
      logic [2:0]   count;       // clamped to four
      logic         bad_count;   // count above four or short non-last item
      logic         first_item;
      logic         last_item;
      logic [31:0]  message_length;
   } m2h_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KMIX2,
      ST_HMIX,
      ST_FIN1,
      ST_FIN2
   } m2h_state_type;

endpackage

/* sv/murmur2_hash32_stream.sv */
// ============================================================================
// murmur2_hash32_stream - streaming 32-bit MurmurHash2 engine
// In the back end an item with no full word (zero to three bytes) uses only
// state IDLE, a full word IDLE, KMIX2 and HMIX; a last item then runs FIN1
// and FIN2, where FIN2 waits while a result in the output register is stalled.
// One shared 32x32 multiplier in the back end serves these steps in turn. Reset is
// synchronous and active high; it clears the configuration registers, the
// queue and the hash state, and the block accepts items in the first cycle after.
// ============================================================================
//
// Structure
//   The front classifies each accepted item: it clamps the byte count to
//   four, flags an over-range count or a short item that is not last, puts
//   the bytes of a full word in the configured order and masks the tail
//   bytes of a short item. Classified entries wait in a two-entry queue.
//   The back pops one entry at a time. On a first item it starts the hash
//   as the seed XOR the declared length (kept modulo 2^LENGTH_WIDTH). A
//   full word is mixed in three multiplier passes, a tail in one. A last
//   item then runs the two final mixes and writes the output register.
//
// Handshake
//   A transfer on either channel takes place at a clock edge where valid is
//   high and stall is low. The input side stalls only when the queue is
//   full; the output register lets the back keep working on later items
//   while a finished result still waits to be taken.
//
// Configuration
//   Register 0 (byte address 0) is the hash seed, register 1 (byte address
//   4) selects the byte order of full words. Registers must be written only
//   while the block is idle, which the block itself does not enforce; both read back through csr_prdata.
//
module murmur2_hash32_stream #(
   parameter int unsigned LENGTH_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  m2h_pkg::m2h_req_type req_data,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output m2h_pkg::m2h_rsp_type rsp_data,

   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   // Configuration registers.
   logic [31:0] seed_ff, seed_in;
   logic        order_ff, order_in;
   logic        csr_write;

   // Front to queue, queue to back.
   m2h_pkg::m2h_entry_type front_entry;
   m2h_pkg::m2h_entry_type queue_head;
   logic                   queue_full;
   logic                   queue_empty;
   logic                   queue_pop;
   logic                   queue_push;

   // ------------------------------------------------------------------
   // Configuration port. pready is tied high, so every access completes
   // in its access cycle. The register index is the word address bit.
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      seed_in  = seed_ff;
      order_in = order_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            m2h_pkg::CSR_IDX_SEED:  seed_in  = csr_pwdata;
            m2h_pkg::CSR_IDX_ORDER: order_in = csr_pwdata[0];
            default:                seed_in  = seed_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         m2h_pkg::CSR_IDX_SEED:  csr_prdata = seed_ff;
         m2h_pkg::CSR_IDX_ORDER: csr_prdata = {31'd0, order_ff};
         default:                csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= 32'd0;
         order_ff <= 1'b0;
      end else begin
         seed_ff  <= seed_in;
         order_ff <= order_in;
      end
   end

   // ------------------------------------------------------------------
   // Front: classify the incoming item on its way into the queue.
   // ------------------------------------------------------------------
   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;

   m2h_front u_front (
      .item            (req_data),
      .word_byte_order (order_ff),
      .entry           (front_entry)
   );

   m2h_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (front_entry),
      .pop        (queue_pop),
      .head       (queue_head),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // ------------------------------------------------------------------
   // Back: hash chain, final mixing and the output register.
   // ------------------------------------------------------------------
   m2h_back #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .hash_seed (seed_ff),
      .head      (queue_head),
      .empty     (queue_empty),
      .pop       (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* sv/m2h_front.sv */
// ============================================================================
// m2h_front - item classifier
// Clamps the byte count, flags count errors, orders the bytes of full words
// and masks tail bytes, producing one queue entry per accepted item.
// ============================================================================
module m2h_front (
   input  m2h_pkg::m2h_req_type   item,
   input  logic                   word_byte_order,
   output m2h_pkg::m2h_entry_type entry
);

   logic [2:0]  count_clamped;
   logic [31:0] swapped;
   logic [31:0] tail_word;

   always_comb begin
      count_clamped = (item.byte_count > m2h_pkg::FULL_WORD_BYTES) ?
                      m2h_pkg::FULL_WORD_BYTES : item.byte_count;
      swapped = {item.data_word[7:0], item.data_word[15:8],
                 item.data_word[23:16], item.data_word[31:24]};

      case (count_clamped)
         3'd1:    tail_word = item.data_word & 32'h0000_00ff;
         3'd2:    tail_word = item.data_word & 32'h0000_ffff;
         3'd3:    tail_word = item.data_word & 32'h00ff_ffff;
         default: tail_word = 32'd0;
      endcase

      entry.count          = count_clamped;
      entry.bad_count      = (item.byte_count > m2h_pkg::FULL_WORD_BYTES) ||
                             ((count_clamped != m2h_pkg::FULL_WORD_BYTES) &&
                              !item.last_item);
      entry.first_item     = item.first_item;
      entry.last_item      = item.last_item;
      entry.message_length = item.message_length;

      if (count_clamped == m2h_pkg::FULL_WORD_BYTES) begin
         entry.kind = m2h_pkg::KIND_FULL;
         entry.word = word_byte_order ? swapped : item.data_word;
      end else if (count_clamped == 3'd0) begin
         entry.kind = m2h_pkg::KIND_NONE;
         entry.word = 32'd0;
      end else begin
         entry.kind = m2h_pkg::KIND_TAIL;
         entry.word = tail_word;
      end
   end

endmodule

/* sv/m2h_queue.sv */
// ============================================================================
// m2h_queue - short entry queue between front and back
// A small register FIFO so the front and the back can stall independently.
// ============================================================================
module m2h_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  m2h_pkg::m2h_entry_type push_entry,
   input  logic                   pop,
   output m2h_pkg::m2h_entry_type head,
   output logic                   full,
   output logic                   empty
);

   localparam int unsigned PTR_W = (m2h_pkg::QUEUE_DEPTH > 1) ?
                                   $clog2(m2h_pkg::QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(m2h_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(m2h_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(m2h_pkg::QUEUE_DEPTH);

   m2h_pkg::m2h_entry_type slots_ff [m2h_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* sv/m2h_back.sv */
// ============================================================================
// m2h_back - hash sequencer
// Takes classified entries from the queue and runs the hash chain through
// one shared multiplier by the mixing constant, then the final mixes, and
// holds the finished result in an output register.
// ============================================================================
module m2h_back #(
   parameter int unsigned LENGTH_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            hash_seed,
   input  m2h_pkg::m2h_entry_type head,
   input  logic                   empty,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output m2h_pkg::m2h_rsp_type   rsp_data
);

   m2h_pkg::m2h_state_type state_ff, state_in;
   logic [31:0]             h_ff, h_in;
   logic [31:0]             k_ff, k_in;
   logic [31:0]             bytes_ff, bytes_in;
   logic [LENGTH_WIDTH-1:0] declared_ff, declared_in;
   logic                    err_ff, err_in;
   logic                    last_ff, last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   m2h_pkg::m2h_rsp_type    rsp_data_ff, rsp_data_in;

   logic [31:0]             mul_a;
   logic [31:0]             mul_p;
   logic [31:0]             h_base;
   logic [31:0]             bytes_base;
   logic [LENGTH_WIDTH-1:0] len_masked;
   logic                    out_free;

   // The one multiplier; every multiply in the hash is by the same constant,
   // and only the low 32 bits of the product are kept.
   assign mul_p = mul_a * m2h_pkg::MIX_MULT;

   assign len_masked = head.message_length[LENGTH_WIDTH-1:0];
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      bytes_in     = bytes_ff;
      declared_in  = declared_ff;
      err_in       = err_ff;
      last_in      = last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop          = 1'b0;
      mul_a        = h_ff;
      h_base       = head.first_item ? (hash_seed ^ 32'(len_masked)) : h_ff;
      bytes_base   = head.first_item ? 32'd0 : bytes_ff;

      unique case (state_ff)
         m2h_pkg::ST_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               last_in  = head.last_item;
               bytes_in = bytes_base + 32'(head.count);
               err_in   = (head.first_item ? 1'b0 : err_ff) | head.bad_count;
               if (head.first_item) begin
                  declared_in = len_masked;
               end
               unique case (head.kind)
                  m2h_pkg::KIND_FULL: begin
                     mul_a    = head.word;
                     k_in     = mul_p;
                     h_in     = h_base;
                     state_in = m2h_pkg::ST_KMIX2;
                  end
                  m2h_pkg::KIND_TAIL: begin
                     mul_a    = h_base ^ head.word;
                     h_in     = mul_p;
                     state_in = head.last_item ? m2h_pkg::ST_FIN1 : m2h_pkg::ST_IDLE;
                  end
                  default: begin
                     h_in     = h_base;
                     state_in = head.last_item ? m2h_pkg::ST_FIN1 : m2h_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         m2h_pkg::ST_KMIX2: begin
            mul_a    = k_ff ^ (k_ff >> m2h_pkg::MIX_SHIFT);
            k_in     = mul_p;
            state_in = m2h_pkg::ST_HMIX;
         end
         m2h_pkg::ST_HMIX: begin
            mul_a    = h_ff;
            h_in     = mul_p ^ k_ff;
            state_in = last_ff ? m2h_pkg::ST_FIN1 : m2h_pkg::ST_IDLE;
         end
         m2h_pkg::ST_FIN1: begin
            mul_a    = h_ff ^ (h_ff >> m2h_pkg::FINAL_SHIFT_A);
            h_in     = mul_p;
            state_in = m2h_pkg::ST_FIN2;
         end
         m2h_pkg::ST_FIN2: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.hash_value   = h_ff ^ (h_ff >> m2h_pkg::FINAL_SHIFT_B);
               rsp_data_in.length_error = err_ff || (bytes_ff != 32'(declared_ff));
               h_in        = 32'd0;
               bytes_in    = 32'd0;
               declared_in = '0;
               err_in      = 1'b0;
               state_in    = m2h_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = m2h_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= m2h_pkg::ST_IDLE;
         h_ff         <= 32'd0;
         bytes_ff     <= 32'd0;
         declared_ff  <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         bytes_ff     <= bytes_in;
         declared_ff  <= declared_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
